[hw/rtl/gnno_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnno_pkg
// shared types and constants of the nearest-neighbor ordering block
// ----------------------------------------------------------------------------
package gnno_pkg;

   // fixed widths of the transaction fields
   localparam int FIELD_BITS = 16;
   localparam int IDX_BITS   = 6;

   // axes per point; the squaring phase after the last axis is the final sum
   localparam int AXES = 3;

   // control from the sequencer to the squared distance unit
   typedef struct packed {
      logic       clear;   // first axis: restart the running sum
      logic [1:0] axis;    // axis squared this cycle
   } sq_ctrl_type;

endpackage

[hw/rtl/gnno_dist_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnno_dist_unit
// shared squaring multiplier and accumulator, one axis per cycle
// ----------------------------------------------------------------------------
module gnno_dist_unit #(
   parameter int COORD_BITS = 16
) (
   input  logic                        clock,
   input  gnno_pkg::sq_ctrl_type       ctrl,
   input  logic [3*COORD_BITS-1:0]     point_a,
   input  logic [3*COORD_BITS-1:0]     point_b,
   output logic [2*COORD_BITS+1:0]     sq_sum
);

   localparam int DIST_W = 2*COORD_BITS + 2;

   logic [COORD_BITS-1:0] a_sel;
   logic [COORD_BITS-1:0] b_sel;
   logic signed [COORD_BITS:0] diff;
   logic [COORD_BITS:0]   diff_abs;
   logic [COORD_BITS-1:0] mag;
   logic [2*COORD_BITS-1:0] mag_sq;
   logic [DIST_W-1:0]     prod_ff;
   logic [DIST_W-1:0]     prod_in;
   logic [DIST_W-1:0]     acc_ff;
   logic [DIST_W-1:0]     acc_in;

   always_comb begin
      case (ctrl.axis)
         2'd0: begin
            a_sel = point_a[0 +: COORD_BITS];
            b_sel = point_b[0 +: COORD_BITS];
         end
         2'd1: begin
            a_sel = point_a[COORD_BITS +: COORD_BITS];
            b_sel = point_b[COORD_BITS +: COORD_BITS];
         end
         2'd2: begin
            a_sel = point_a[2*COORD_BITS +: COORD_BITS];
            b_sel = point_b[2*COORD_BITS +: COORD_BITS];
         end
         default: begin
            a_sel = '0;
            b_sel = '0;
         end
      endcase
   end

   // difference one bit wider, magnitude fits in COORD_BITS
   assign diff     = $signed({a_sel[COORD_BITS-1], a_sel})
                   - $signed({b_sel[COORD_BITS-1], b_sel});
   assign diff_abs = diff[COORD_BITS] ? $unsigned(-diff) : $unsigned(diff);
   assign mag      = diff_abs[COORD_BITS-1:0];

   assign mag_sq  = mag * mag;
   assign prod_in = DIST_W'(mag_sq);
   assign acc_in  = ctrl.clear ? '0 : acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign sq_sum = acc_ff + prod_ff;

endmodule

[hw/rtl/greedy_nearest_neighbor_ordering_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_nearest_neighbor_ordering_top
// loads 3-d points and emits a greedy nearest-neighbor visiting order
// ----------------------------------------------------------------------------
//  channel  | ports                                           | handshake
//  ---------+-------------------------------------------------+---------------------------
//  request  | req_x_coord, req_y_coord, req_z_coord,          | start high, busy low
//           | req_last_point                                  |
//  response | rsp_point_index, rsp_path_end                   | rsp_valid, one cycle, no stall
//
//  a point that is not last is stored and busy stays low
//  the last point (or the MAX_POINTS-th) starts a run: S_LOAD0 and S_FETCH read point 0,
//  then each path step but the last emits the current point, scans the points and closes
//  the scan; a used point is skipped, an unused one gets a memory read, three squarings,
//  sum and compare on the single squaring multiplier, which takes one axis at a time
//  reset is synchronous; results are strobed for one cycle each and cannot be stalled
// ----------------------------------------------------------------------------
module greedy_nearest_neighbor_ordering_top #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request transaction
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [gnno_pkg::FIELD_BITS-1:0] req_x_coord,
   input  logic signed [gnno_pkg::FIELD_BITS-1:0] req_y_coord,
   input  logic signed [gnno_pkg::FIELD_BITS-1:0] req_z_coord,
   input  logic                                  req_last_point,
   // response transaction
   output logic                                  rsp_valid,
   output logic [gnno_pkg::IDX_BITS-1:0]         rsp_point_index,
   output logic                                  rsp_path_end
);

   localparam int IDX_W  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int PT_W   = 3 * COORD_BITS;
   localparam int DIST_W = 2 * COORD_BITS + 2;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;  // loading points
   localparam logic [2:0] S_LOAD0 = 3'd1;  // read point 0
   localparam logic [2:0] S_FETCH = 3'd2;  // take point 0 as current
   localparam logic [2:0] S_STEP  = 3'd3;  // emit current, start a scan or end the run
   localparam logic [2:0] S_SCAN  = 3'd4;  // pick next candidate or close the scan
   localparam logic [2:0] S_MUL   = 3'd5;  // squared distance of one candidate

   localparam logic [1:0] LAST_AXIS = 2'(gnno_pkg::AXES);

   // point store, reads registered
   logic [PT_W-1:0]       point_mem_ff [MAX_POINTS];
   logic [PT_W-1:0]       rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      npts_ff, npts_in;
   logic [CNT_W-1:0]      remain_ff, remain_in;
   logic [CNT_W-1:0]      cand_ff, cand_in;
   logic [1:0]            axis_ff, axis_in;
   logic [MAX_POINTS-1:0] used_ff, used_in;
   logic [IDX_W-1:0]      cur_idx_ff, cur_idx_in;
   logic [PT_W-1:0]       cur_pt_ff, cur_pt_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [PT_W-1:0]       best_pt_ff, best_pt_in;
   logic [DIST_W-1:0]     best_d_ff, best_d_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic                  rsp_end_ff, rsp_end_in;

   logic                  accept;
   logic                  run_go;
   logic [PT_W-1:0]       wr_point;
   logic [DIST_W-1:0]     cand_dist;
   gnno_pkg::sq_ctrl_type sq_ctrl;

   assign accept = start && (state_ff == S_IDLE);

   // the low COORD_BITS of each field, taken as raw bits
   assign wr_point = {COORD_BITS'($unsigned(req_z_coord)),
                      COORD_BITS'($unsigned(req_y_coord)),
                      COORD_BITS'($unsigned(req_x_coord))};

   // run starts on the marked point or when the store fills
   assign run_go = req_last_point || (count_ff == CNT_W'(MAX_POINTS - 1));

   assign rd_addr = (state_ff == S_LOAD0) ? '0 : cand_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         point_mem_ff[count_ff[IDX_W-1:0]] <= wr_point;
      end
      rd_data_ff <= point_mem_ff[rd_addr];
   end

   assign sq_ctrl.clear = (axis_ff == 2'd0);
   assign sq_ctrl.axis  = axis_ff;

   gnno_dist_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock   (clock),
      .ctrl    (sq_ctrl),
      .point_a (cur_pt_ff),
      .point_b (rd_data_ff),
      .sq_sum  (cand_dist)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      npts_in      = npts_ff;
      remain_in    = remain_ff;
      cand_in      = cand_ff;
      axis_in      = axis_ff;
      used_in      = used_ff;
      cur_idx_in   = cur_idx_ff;
      cur_pt_in    = cur_pt_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_pt_in   = best_pt_ff;
      best_d_in    = best_d_ff;
      rsp_valid_in = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      rsp_end_in   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (run_go) begin
                  npts_in    = count_ff + 1'b1;
                  remain_in  = count_ff + 1'b1;
                  count_in   = '0;
                  used_in    = '0;
                  cur_idx_in = '0;
                  state_in   = S_LOAD0;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         S_LOAD0: begin
            state_in = S_FETCH;
         end
         S_FETCH: begin
            cur_pt_in = rd_data_ff;
            state_in  = S_STEP;
         end
         S_STEP: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = cur_idx_ff;
            if (remain_ff > CNT_W'(1)) begin
               used_in[cur_idx_ff] = 1'b1;
               remain_in           = remain_ff - 1'b1;
               cand_in             = '0;
               found_in            = 1'b0;
               state_in            = S_SCAN;
            end else begin
               rsp_end_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SCAN: begin
            if (cand_ff == npts_ff) begin
               // scan done: move to the nearest unused point
               cur_idx_in = best_idx_ff;
               cur_pt_in  = best_pt_ff;
               state_in   = S_STEP;
            end else if (used_ff[cand_ff[IDX_W-1:0]]) begin
               cand_in = cand_ff + 1'b1;
            end else begin
               axis_in  = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (axis_ff == LAST_AXIS) begin
               // strict compare keeps the lowest index on a tie
               if (!found_ff || (cand_dist < best_d_ff)) begin
                  found_in    = 1'b1;
                  best_d_in   = cand_dist;
                  best_idx_in = cand_ff[IDX_W-1:0];
                  best_pt_in  = rd_data_ff;
               end
               cand_in  = cand_ff + 1'b1;
               state_in = S_SCAN;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_end_ff   <= 1'b0;
         cur_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_end_ff   <= rsp_end_in;
         cur_idx_ff   <= cur_idx_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      npts_ff     <= npts_in;
      remain_ff   <= remain_in;
      cand_ff     <= cand_in;
      axis_ff     <= axis_in;
      cur_pt_ff   <= cur_pt_in;
      best_idx_ff <= best_idx_in;
      best_pt_ff  <= best_pt_in;
      best_d_ff   <= best_d_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_index = gnno_pkg::IDX_BITS'(rsp_idx_ff);
   assign rsp_path_end    = rsp_end_ff;

endmodule

[hw/rtl/gnno_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnno_checker
// port-level checks of the run sequencing, bound to the top level
// ----------------------------------------------------------------------------
module gnno_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_path_end
);

   // end marker only rides on a strobed transaction
   a_end_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_path_end |-> rsp_valid)
      else $error("path end without response strobe");

   // path indices before the last come while the run is still going
   a_mid_while_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_path_end) |-> busy)
      else $error("mid-path response outside a run");

   // the run is over when the final index shows
   a_end_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_path_end) |-> !busy)
      else $error("still busy at path end");

   // a run opens with setup cycles before the first index
   a_no_resp_at_run_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> !rsp_valid)
      else $error("response in the first cycle of a run");

endmodule

bind greedy_nearest_neighbor_ordering_top gnno_checker u_gnno_checker (
   .clock        (clock),
   .reset        (reset),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_path_end (rsp_path_end)
);

[bench/greedy_nearest_neighbor_ordering_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_nearest_neighbor_ordering_top_tb
// self-checking bench for the greedy nearest-neighbor point ordering block
// ----------------------------------------------------------------------------
// point sets go in one point per request transaction
// each accepted point also goes into a local model of the block
// a closing point or a full set makes the model build the expected order
// each response transaction is checked against the oldest expected entry
// directed sets: single point, coordinate extremes, equal distances, duplicates,
// line walk; random sets at three sender idle rates, then a run filling the store
// ----------------------------------------------------------------------------
module greedy_nearest_neighbor_ordering_top_tb;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int FB         = gnno_pkg::FIELD_BITS;
   localparam int IB         = gnno_pkg::IDX_BITS;

   // upper bound on one path step, taking every point as unused
   localparam int STEP_CYCLES  = 5 * MAX_POINTS + 4;
   // silence allowed before the run is declared hung
   localparam int STALL_LIMIT  = 10 * (STEP_CYCLES + 16);

   // one expected response transaction
   typedef struct packed {
      logic [IB-1:0] point_index;
      logic          path_end;
   } path_entry_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic signed [FB-1:0] req_x_coord;
   logic signed [FB-1:0] req_y_coord;
   logic signed [FB-1:0] req_z_coord;
   logic                 req_last_point;
   logic                 rsp_valid;
   logic [IB-1:0]        rsp_point_index;
   logic                 rsp_path_end;

   // local copy of the loaded set
   longint      loaded_x [MAX_POINTS];
   longint      loaded_y [MAX_POINTS];
   longint      loaded_z [MAX_POINTS];
   int unsigned loaded_count;

   // visiting order still waiting to come out of the block
   path_entry_type expected_path_q [$];

   int mismatch_count = 0;
   int sender_idle_pct;
   int quiet_cycles = 0;

   greedy_nearest_neighbor_ordering_top #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_z_coord     (req_z_coord),
      .req_last_point  (req_last_point),
      .rsp_valid       (rsp_valid),
      .rsp_point_index (rsp_point_index),
      .rsp_path_end    (rsp_path_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // model of the block
   // ---------------------------------------------------------------------------

   // low COORD_BITS bits of the field, sign-extended from that width
   function automatic longint coord_value(input logic [FB-1:0] raw);
      logic [63:0] v;
      v = {{(64-FB){1'b0}}, raw} & ((64'd1 << COORD_BITS) - 64'd1);
      if (v[COORD_BITS-1])
         v = v - (64'd1 << COORD_BITS);
      return $signed(v);
   endfunction

   function automatic longint unsigned squared_distance(input int unsigned a,
                                                         input int unsigned b);
      longint          d [3];
      longint unsigned sum;
      longint unsigned m;
      d[0] = loaded_x[a] - loaded_x[b];
      d[1] = loaded_y[a] - loaded_y[b];
      d[2] = loaded_z[a] - loaded_z[b];
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         m = (d[k] < 0) ? longint'(-d[k]) : longint'(d[k]);
         sum += m * m;
      end
      return sum;
   endfunction

   // greedy walk from point 0, ties to the lowest index; empties the set
   task automatic build_greedy_path();
      bit              visited [MAX_POINTS];
      int unsigned     remaining;
      int unsigned     here;
      int unsigned     best;
      longint unsigned best_d;
      longint unsigned d;
      bit              found;
      path_entry_type  step;
      visited   = '{default: 1'b0};
      remaining = loaded_count;
      here      = 0;
      while (remaining > 1) begin
         visited[here] = 1'b1;
         remaining--;
         step.point_index = here[IB-1:0];
         step.path_end    = 1'b0;
         expected_path_q  = {expected_path_q, step};
         found  = 1'b0;
         best   = 0;
         best_d = 0;
         for (int unsigned i = 0; i < loaded_count; i++) begin
            if (!visited[i]) begin
               d = squared_distance(here, i);
               if (!found || d < best_d) begin
                  found  = 1'b1;
                  best_d = d;
                  best   = i;
               end
            end
         end
         here = best;
      end
      step.point_index = here[IB-1:0];
      step.path_end    = 1'b1;
      expected_path_q  = {expected_path_q, step};
      loaded_count = 0;
   endtask

   task automatic load_point(input logic [FB-1:0] x, input logic [FB-1:0] y,
                             input logic [FB-1:0] z, input logic last);
      loaded_x[loaded_count] = coord_value(x);
      loaded_y[loaded_count] = coord_value(y);
      loaded_z[loaded_count] = coord_value(z);
      loaded_count++;
      if (last || loaded_count >= MAX_POINTS)
         build_greedy_path();
   endtask

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // called at a falling edge, returns at the falling edge after acceptance;
   // start is left high so a following point goes out without a gap
   task automatic send_point(input logic [FB-1:0] x, input logic [FB-1:0] y,
                             input logic [FB-1:0] z, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start          = 1'b1;
      req_x_coord    = x;
      req_y_coord    = y;
      req_z_coord    = z;
      req_last_point = last;
      // transaction completes at the first rising edge that sees busy low
      do
         @(posedge clock);
      while (busy);
      load_point(x, y, z, last);
      @(negedge clock);
   endtask

   // mix of full-range, extreme and clustered values so equal distances occur
   function automatic logic [FB-1:0] random_coord();
      int v;
      case ($urandom_range(3))
         0: return FB'($urandom);
         1: begin
            v = $urandom_range(6);
            return FB'(v - 3);
         end
         2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: begin
            v = $urandom_range(400);
            return FB'(v - 200);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // two sets of one point each: path is index 0 with the end mark
   task automatic test_single_point();
      send_point(16'h8000, 16'h7fff, 16'h0000, 1'b1);
      send_point(16'hffff, 16'h0001, 16'h8000, 1'b1);
   endtask

   // opposite corners give the largest distance
   task automatic test_extreme_pair();
      send_point(16'h7fff, 16'h8000, 16'h7fff, 1'b0);
      send_point(16'h8000, 16'h7fff, 16'h8000, 1'b0);
      send_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
   endtask

   // equal distances from the current point go to the lowest index
   task automatic test_distance_ties();
      send_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_point(16'h0002, 16'h0000, 16'h0000, 1'b0);
      send_point(16'hfffe, 16'h0000, 16'h0000, 1'b0);
      send_point(16'h0000, 16'h0002, 16'h0000, 1'b0);
      send_point(16'h0000, 16'h0000, 16'hfffe, 1'b1);
   endtask

   // coincident points sit at distance zero
   task automatic test_duplicate_points();
      send_point(16'h0005, 16'h0005, 16'h0005, 1'b0);
      send_point(16'h1234, 16'hedcb, 16'h5555, 1'b0);
      send_point(16'h0005, 16'h0005, 16'h0005, 1'b0);
      send_point(16'h1234, 16'hedcb, 16'h5555, 1'b0);
      send_point(16'haaaa, 16'h5555, 16'haaaa, 1'b1);
   endtask

   // points on a line, arriving out of order
   task automatic test_line_walk();
      send_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_point(16'h0064, 16'h0000, 16'h0000, 1'b0);
      send_point(16'h000a, 16'h0000, 16'h0000, 1'b0);
      send_point(16'hff9c, 16'h0000, 16'h0000, 1'b0);
      send_point(16'h0032, 16'h0000, 16'h0000, 1'b1);
   endtask

   // random sets, mostly small, each closed by its last point
   task automatic test_random_sets(input int idle_pct, input int point_target);
      int sent;
      int set_size;
      sender_idle_pct = idle_pct;
      sent = 0;
      while (sent < point_target) begin
         set_size = ($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
         for (int i = 0; i < set_size; i++)
            send_point(random_coord(), random_coord(), random_coord(), i == set_size - 1);
         sent += set_size;
      end
   endtask

   // never mark a point last: the store filling up must start the run
   task automatic test_full_set();
      for (int i = 0; i < MAX_POINTS; i++)
         send_point(random_coord(), random_coord(), random_coord(), 1'b0);
   endtask

   // ---------------------------------------------------------------------------
   // response checking
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : check_responses
      path_entry_type want;
      if (!reset && rsp_valid) begin
         if (expected_path_q.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected response index %0d end %0b", $realtime,
                        rsp_point_index, rsp_path_end);
            mismatch_count++;
         end else begin
            want = expected_path_q.pop_front();
            if (rsp_point_index !== want.point_index || rsp_path_end !== want.path_end) begin
               if (mismatch_count < 10)
                  $display("%0t: mismatch: expected index %0d end %0b, got index %0d end %0b",
                           $realtime, want.point_index, want.path_end,
                           rsp_point_index, rsp_path_end);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: any accepted transaction on either side restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_x_coord     = '0;
      req_y_coord     = '0;
      req_z_coord     = '0;
      req_last_point  = 1'b0;
      loaded_count    = 0;
      sender_idle_pct = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed sets, back to back
      test_single_point();
      test_extreme_pair();
      test_distance_ties();
      test_duplicate_points();
      test_line_walk();

      // sender idles now and then, then often, then never
      test_random_sets(30, 10);
      test_random_sets(80, 10);
      test_random_sets(0, 6);
      test_full_set();

      start = 1'b0;

      // let the last path drain, then watch for stray responses
      while (expected_path_q.size() != 0)
         @(posedge clock);
      repeat (STEP_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_path_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[greedy_nearest_neighbor_ordering_top.f]
hw/rtl/gnno_pkg.sv
hw/rtl/gnno_dist_unit.sv
hw/rtl/greedy_nearest_neighbor_ordering_top.sv
hw/rtl/gnno_checker.sv
bench/greedy_nearest_neighbor_ordering_top_tb.sv
